// ----- hdl/code_lock_controller_unit_defines.svh -----
// assertion macros for the checker file
`ifndef CODE_LOCK_CONTROLLER_UNIT_DEFINES_SVH
`define CODE_LOCK_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/clc_pkg.sv -----
`default_nettype none
package clc_pkg;

	localparam int CODE_LENGTH = 4;
	localparam int CNT_W = $clog2(CODE_LENGTH + 1);
	localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	localparam int KEY_W = 8;
	localparam int CODE_W = 32;
	localparam int SAMPLE_W = 10;
	localparam int WIN_W = 7;
	localparam int ATT_W = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [KEY_W-1:0] KEY_ASTERISK = 8'h2A;

	// sample / 10 as (sample * 205) >> 11, exact for ten bit samples
	localparam int DIV10_MUL = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int DIV10_MUL_W = 8;
	localparam int DIV10_PROD_W = SAMPLE_W + DIV10_MUL_W;

	localparam logic [2:0] BEEP_NONE = 3'd0;
	localparam logic [2:0] BEEP_CONFIRM = 3'd2;
	localparam logic [2:0] BEEP_WRONG = 3'd6;
	localparam logic [8:0] SERVO_OPEN = 9'd276;
	localparam logic [8:0] SERVO_CLOSED = 9'd59;

	localparam logic [CODE_W-1:0] UNLOCK_CODE_RST = 32'd825571640;
	localparam logic [CODE_W-1:0] CLOSE_CODE_RST = 32'd589505315;
	localparam logic [KEY_W-1:0] CONFIRM_KEY_RST = 8'd65;
	localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 4'd3;
	localparam logic [WIN_W-1:0] WINDOW_LOW_RST = 7'd49;
	localparam logic [WIN_W-1:0] WINDOW_HIGH_RST = 7'd51;

	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_KEY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 3'd5;

	typedef enum logic [3:0] {
		EV_NONE = 4'd0,
		EV_KEY_STORED = 4'd1,
		EV_WRONG_CODE = 4'd2,
		EV_CORRECT_CODE = 4'd3,
		EV_CLOSED = 4'd4,
		EV_FIRST_DIAL = 4'd5,
		EV_OPENED = 4'd6,
		EV_ALARM = 4'd7,
		EV_ALARM_CLEARED = 4'd8
	} event_t;

	typedef struct packed {
		logic [CODE_W-1:0] unlock_code;
		logic [CODE_W-1:0] close_code;
		logic [KEY_W-1:0] confirm_key;
		logic [ATT_W-1:0] max_attempts;
		logic [WIN_W-1:0] window_low;
		logic [WIN_W-1:0] window_high;
	} cfg_t;

	typedef struct packed {
		logic action;
		logic [KEY_W-1:0] key_code;
		logic [SAMPLE_W-1:0] dial_sample;
		logic button_pressed;
	} item_t;

	typedef struct packed {
		logic [3:0] event_res;
		logic door_open;
		logic alarm_active;
		logic [2:0] beep_count;
		logic [8:0] servo_position;
		logic [2:0] keys_entered;
		logic [1:0] dial_step;
		logic [ATT_W-1:0] attempts_left;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/clc_ifs.sv -----
`default_nettype none
interface clc_item_if;
	import clc_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [KEY_W-1:0] key_code;
	logic [SAMPLE_W-1:0] dial_sample;
	logic button_pressed;

	modport source (output valid, action, key_code, dial_sample, button_pressed, input ready);
	modport sink (input valid, action, key_code, dial_sample, button_pressed, output ready);
endinterface

interface clc_result_if;
	import clc_pkg::*;
	logic valid;
	logic ready;
	logic [3:0] event_res;
	logic door_open;
	logic alarm_active;
	logic [2:0] beep_count;
	logic [8:0] servo_position;
	logic [2:0] keys_entered;
	logic [1:0] dial_step;
	logic [ATT_W-1:0] attempts_left;

	modport source (output valid, event_res, door_open, alarm_active, beep_count,
		servo_position, keys_entered, dial_step, attempts_left, input ready);
	modport sink (input valid, event_res, door_open, alarm_active, beep_count,
		servo_position, keys_entered, dial_step, attempts_left, output ready);
endinterface
`default_nettype wire

// ----- hdl/clc_cfg_regs.sv -----
`default_nettype none
module clc_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic we,
	input wire logic [clc_pkg::CFG_IDX_W-1:0] index,
	input wire logic [clc_pkg::CODE_W-1:0] wdata,
	output clc_pkg::cfg_t cfg
);
	import clc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unlock_code <= UNLOCK_CODE_RST;
			cfg_q.close_code <= CLOSE_CODE_RST;
			cfg_q.confirm_key <= CONFIRM_KEY_RST;
			cfg_q.max_attempts <= MAX_ATTEMPTS_RST;
			cfg_q.window_low <= WINDOW_LOW_RST;
			cfg_q.window_high <= WINDOW_HIGH_RST;
		end else if (we) begin
			case (index)
				CFG_UNLOCK_CODE: cfg_q.unlock_code <= wdata;
				CFG_CLOSE_CODE: cfg_q.close_code <= wdata;
				CFG_CONFIRM_KEY: cfg_q.confirm_key <= wdata[KEY_W-1:0];
				CFG_MAX_ATTEMPTS: cfg_q.max_attempts <= wdata[ATT_W-1:0];
				CFG_WINDOW_LOW: cfg_q.window_low <= wdata[WIN_W-1:0];
				CFG_WINDOW_HIGH: cfg_q.window_high <= wdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// ----- hdl/clc_in_stage.sv -----
`default_nettype none
module clc_in_stage (
	input wire logic clk,
	input wire logic arst_n,
	clc_item_if.sink item_ch,
	input wire logic advance,
	output logic valid_s1,
	output clc_pkg::item_t item_s1
);
	import clc_pkg::*;

	logic load;

	assign item_ch.ready = !valid_s1 || advance;
	assign load = item_ch.valid && item_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.action <= item_ch.action;
			item_s1.key_code <= item_ch.key_code;
			item_s1.dial_sample <= item_ch.dial_sample;
			item_s1.button_pressed <= item_ch.button_pressed;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/clc_core.sv -----
`default_nettype none
module clc_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire clc_pkg::item_t item,
	input wire clc_pkg::cfg_t cfg,
	output clc_pkg::result_t result
);
	import clc_pkg::*;

	typedef enum logic [1:0] {
		MODE_ENTRY = 2'd0,
		MODE_ALARM = 2'd1,
		MODE_DIAL = 2'd2
	} mode_t;

	logic [KEY_W-1:0] entry_q [CODE_LENGTH];
	logic [CNT_W-1:0] count_q;
	mode_t mode_q;
	logic door_q;
	logic [ATT_W-1:0] att_q;
	logic [1:0] prog_q;

	logic [KEY_W-1:0] entry_d [CODE_LENGTH];
	logic [CNT_W-1:0] count_d;
	mode_t mode_d;
	logic door_d;
	logic [ATT_W-1:0] att_d;
	logic [1:0] prog_d;
	event_t ev;
	logic [2:0] beep;

	logic [CODE_W-1:0] packed_code;
	logic [DIV10_PROD_W-1:0] prod;
	logic [WIN_W-1:0] scaled;
	logic in_window;
	logic [ATT_W-1:0] att_dec;

	always_comb begin
		packed_code = '0;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			packed_code = {packed_code[CODE_W-KEY_W-1:0], entry_q[i]};
		end
	end

	assign prod = DIV10_PROD_W'(item.dial_sample) * DIV10_PROD_W'(DIV10_MUL);
	assign scaled = prod[DIV10_SHIFT +: WIN_W];
	assign in_window = (scaled >= cfg.window_low) && (scaled <= cfg.window_high);
	assign att_dec = (att_q == '0) ? '0 : att_q - 1'b1;

	always_comb begin
		entry_d = entry_q;
		count_d = count_q;
		mode_d = mode_q;
		door_d = door_q;
		att_d = att_q;
		prog_d = prog_q;
		ev = EV_NONE;
		beep = BEEP_NONE;
		case (mode_q)
			MODE_ALARM: begin
				if (item.button_pressed) begin
					mode_d = MODE_ENTRY;
					att_d = cfg.max_attempts;
					count_d = '0;
					for (int i = 0; i < CODE_LENGTH; i++) entry_d[i] = KEY_ASTERISK;
					ev = EV_ALARM_CLEARED;
				end
			end
			MODE_DIAL: begin
				if (item.action && item.button_pressed && in_window) begin
					beep = BEEP_CONFIRM;
					if (prog_q == 2'd0) begin
						prog_d = 2'd1;
						ev = EV_FIRST_DIAL;
					end else begin
						prog_d = 2'd2;
						door_d = 1'b1;
						mode_d = MODE_ENTRY;
						ev = EV_OPENED;
					end
				end
			end
			default: begin
				mode_d = MODE_ENTRY;
				if (!item.action) begin
					if (count_q < CNT_W'(CODE_LENGTH)) begin
						entry_d[count_q[IDX_W-1:0]] = item.key_code;
						count_d = count_q + 1'b1;
						ev = EV_KEY_STORED;
					end else begin
						if (item.key_code == cfg.confirm_key) begin
							if (packed_code == cfg.close_code && door_q) begin
								door_d = 1'b0;
								prog_d = 2'd0;
								beep = BEEP_CONFIRM;
								ev = EV_CLOSED;
							end else if (packed_code != cfg.unlock_code) begin
								beep = BEEP_WRONG;
								att_d = att_dec;
								if (att_dec == '0) begin
									mode_d = MODE_ALARM;
									ev = EV_ALARM;
								end else begin
									ev = EV_WRONG_CODE;
								end
							end else begin
								beep = BEEP_CONFIRM;
								if (door_q) begin
									ev = EV_OPENED;
								end else begin
									mode_d = MODE_DIAL;
									ev = EV_CORRECT_CODE;
								end
							end
						end
						count_d = '0;
						for (int i = 0; i < CODE_LENGTH; i++) entry_d[i] = KEY_ASTERISK;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_LENGTH; i++) entry_q[i] <= KEY_ASTERISK;
			count_q <= '0;
			mode_q <= MODE_ENTRY;
			door_q <= 1'b0;
			att_q <= MAX_ATTEMPTS_RST;
			prog_q <= 2'd0;
		end else if (fire) begin
			entry_q <= entry_d;
			count_q <= count_d;
			mode_q <= mode_d;
			door_q <= door_d;
			att_q <= att_d;
			prog_q <= prog_d;
		end
	end

	always_comb begin
		result.event_res = ev;
		result.door_open = door_d;
		result.alarm_active = (mode_d == MODE_ALARM);
		result.beep_count = beep;
		result.servo_position = door_d ? SERVO_OPEN : SERVO_CLOSED;
		result.keys_entered = 3'(count_d);
		result.dial_step = prog_d;
		result.attempts_left = att_d;
	end
endmodule
`default_nettype wire

// ----- hdl/clc_out_stage.sv -----
`default_nettype none
module clc_out_stage (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid_s1,
	input wire clc_pkg::result_t result,
	output logic advance,
	clc_result_if.source result_ch
);
	import clc_pkg::*;

	logic valid_q;
	result_t result_q;

	assign advance = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign result_ch.valid = valid_q;
	assign result_ch.event_res = result_q.event_res;
	assign result_ch.door_open = result_q.door_open;
	assign result_ch.alarm_active = result_q.alarm_active;
	assign result_ch.beep_count = result_q.beep_count;
	assign result_ch.servo_position = result_q.servo_position;
	assign result_ch.keys_entered = result_q.keys_entered;
	assign result_ch.dial_step = result_q.dial_step;
	assign result_ch.attempts_left = result_q.attempts_left;
endmodule
`default_nettype wire

// ----- hdl/code_lock_controller_unit.sv -----
// Safe lock controller. Each item on item_ch is a keypad key (action 0) or a dial sample
// with the button state (action 1), and produces exactly one result on result_ch with the
// event code and a snapshot of door, alarm, beep count, servo value, entry length, dial
// stage and attempts left. The input register takes the item at acceptance, then the
// decision logic and the lock state update load the result register when it is free or
// being read by result_ch. One item is taken every cycle while result_ch keeps up; one
// more item is held in the input register while a result waits. Configuration is taken
// on cfg_we at cfg_index (0 unlock code, 1 close code, 2 confirm key, 3 max attempts,
// 4 window low, 5 window high); write it only while no item is in flight.
`default_nettype none
module code_lock_controller_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [clc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [clc_pkg::CODE_W-1:0] cfg_wdata,
	clc_item_if.sink item_ch,
	clc_result_if.source result_ch
);
	import clc_pkg::*;

	cfg_t cfg;
	item_t item_s1;
	result_t result;
	logic valid_s1;
	logic advance;

	clc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.index(cfg_index),
		.wdata(cfg_wdata),
		.cfg(cfg)
	);

	clc_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.item_ch(item_ch),
		.advance(advance),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	clc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(valid_s1 && advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	clc_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.result(result),
		.advance(advance),
		.result_ch(result_ch)
	);
endmodule
`default_nettype wire

// ----- hdl/clc_checker.sv -----
`default_nettype none
`include "code_lock_controller_unit_defines.svh"
module clc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [3:0] out_event,
	input wire logic door_open,
	input wire logic alarm_active,
	input wire logic [2:0] beep,
	input wire logic [8:0] servo,
	input wire logic [3:0] attempts
);
	import clc_pkg::*;

	`CLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event), "stalled result dropped or changed")
	`CLC_ASSERT_NOW(a_servo_door, out_valid, (door_open && servo == SERVO_OPEN) || (!door_open && servo == SERVO_CLOSED), "servo value disagrees with door")
	`CLC_ASSERT_NOW(a_open_evt, out_valid && out_event == EV_OPENED, door_open && beep == BEEP_CONFIRM, "open event without open door")
	`CLC_ASSERT_NOW(a_alarm_evt, out_valid && out_event == EV_ALARM, alarm_active && beep == BEEP_WRONG && attempts == '0, "alarm event inconsistent")
endmodule

bind code_lock_controller_unit clc_checker u_clc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.out_event(result_ch.event_res),
	.door_open(result_ch.door_open),
	.alarm_active(result_ch.alarm_active),
	.beep(result_ch.beep_count),
	.servo(result_ch.servo_position),
	.attempts(result_ch.attempts_left)
);
`default_nettype wire
